### src/mfau_pkg.sv
// ----------------------------------------------------------------------------
// mfau_pkg
// Shared types and constants for the motor feedback angle unwrap block.
// ----------------------------------------------------------------------------
package mfau_pkg;

  // Table geometry: two buses with a fixed number of slots each.
  localparam int SLOTS_PER_BUS = 8;
  localparam int TABLE_SIZE    = 2 * SLOTS_PER_BUS;
  localparam int IDX_W         = $clog2(TABLE_SIZE);

  // Encoder range and the half range used for unwrapping.
  localparam int ENCODER_COUNTS = 8192;
  localparam int STEP_W         = 18;
  localparam logic signed [STEP_W-1:0] HALF_RANGE  = STEP_W'(ENCODER_COUNTS / 2);
  localparam logic signed [STEP_W-1:0] FULL_RANGE  = STEP_W'(ENCODER_COUNTS);

  // Identifiers of interest.
  localparam logic [10:0] BASE_ID   = 11'h201;
  localparam logic [10:0] BACKUP_ID = 11'h203;

  // A classified frame, as queued between the front and the back.
  typedef struct packed {
    logic              id_ok;
    logic              bus;
    logic [2:0]        slot;
    logic [IDX_W-1:0]  idx;
    logic              backup;
    logic [15:0]       angle;
    logic [15:0]       speed;
    logic [15:0]       current;
    logic [7:0]        temperature;
  } frame_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // Table row for a bus and slot.
  function automatic logic [IDX_W-1:0] slot_index(input logic bus, input logic [2:0] slot);
    slot_index = IDX_W'(bus) * IDX_W'(SLOTS_PER_BUS) + IDX_W'(slot);
  endfunction

endpackage

### src/mfau_front.sv
// ----------------------------------------------------------------------------
// mfau_front
// Accepts frames, unpacks the payload and classifies the identifier.
// ----------------------------------------------------------------------------
module mfau_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,   // std_id, byte0, byte1, ..., byte6, zero pad
  input  logic               s_tuser,   // bus
  input  mfau_pkg::q_stat_t  q_stat,
  output logic               push,
  output mfau_pkg::frame_t   push_frame
);

  logic [10:0] std_id;
  logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
  logic        in_range;
  logic [10:0] slot_full;

  assign std_id = s_tdata[10:0];
  assign b0     = s_tdata[18:11];
  assign b1     = s_tdata[26:19];
  assign b2     = s_tdata[34:27];
  assign b3     = s_tdata[42:35];
  assign b4     = s_tdata[50:43];
  assign b5     = s_tdata[58:51];
  assign b6     = s_tdata[66:59];

  // An item goes straight into the queue while it has room.
  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  // Identifier check and slot decode.
  assign in_range  = (std_id >= mfau_pkg::BASE_ID) &&
                     (std_id < mfau_pkg::BASE_ID + 11'(mfau_pkg::SLOTS_PER_BUS));
  assign slot_full = std_id - mfau_pkg::BASE_ID;

  always_comb begin
    push_frame.id_ok       = in_range;
    push_frame.bus         = s_tuser;
    push_frame.slot        = in_range ? slot_full[2:0] : 3'd0;
    push_frame.idx         = mfau_pkg::slot_index(s_tuser, slot_full[2:0]);
    push_frame.backup      = in_range && s_tuser && (std_id == mfau_pkg::BACKUP_ID);
    push_frame.angle       = {b0, b1};
    push_frame.speed       = {b2, b3};
    push_frame.current     = {b4, b5};
    push_frame.temperature = b6;
  end

endmodule

### src/mfau_queue.sv
// ----------------------------------------------------------------------------
// mfau_queue
// Two-entry queue of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module mfau_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mfau_pkg::frame_t   push_frame,
  input  logic               pop,
  output mfau_pkg::frame_t   head,
  output mfau_pkg::q_stat_t  q_stat
);

  mfau_pkg::frame_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.valid = (count != 2'd0);
  assign q_stat.full  = (count == 2'd2);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/mfau_back.sv
// ----------------------------------------------------------------------------
// mfau_back
// Per-slot angle table, unwrap and multi-turn sum, with the output register.
// ----------------------------------------------------------------------------
module mfau_back (
  input  logic               clk,
  input  logic               rst,
  input  mfau_pkg::frame_t   head,
  input  mfau_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [111:0]       m_tdata,   // motor_index, angle, speed, current,
                                        // temperature, previous_angle, turn_sum, zero pad
  output logic [2:0]         m_tuser    // id_ok, bus_out, backup_update
);

  localparam int SW = mfau_pkg::STEP_W;

  // Slot table; a row that is not seen reads as the frame's own angle, sum zero.
  logic [15:0] last_angle [mfau_pkg::TABLE_SIZE];
  logic [31:0] angle_sum  [mfau_pkg::TABLE_SIZE];
  logic [mfau_pkg::TABLE_SIZE-1:0] seen;

  logic            row_seen;
  logic [15:0]     prev;
  logic [31:0]     old_sum;
  logic signed [SW-1:0] step_raw;
  logic signed [SW-1:0] step;
  logic [31:0]     new_sum;
  logic            upd;

  // Take the head whenever the output register is free or being emptied.
  assign pop = q_stat.valid && (!m_tvalid || m_tready);
  assign upd = pop && head.id_ok;

  // Read the row and unwrap the step.
  always_comb begin
    row_seen = seen[head.idx];
    prev     = row_seen ? last_angle[head.idx] : head.angle;
    old_sum  = row_seen ? angle_sum[head.idx] : 32'd0;
    step_raw = $signed({2'b00, head.angle}) - $signed({2'b00, prev});
    if (step_raw < -mfau_pkg::HALF_RANGE) begin
      step = step_raw + mfau_pkg::FULL_RANGE;
    end else if (step_raw > mfau_pkg::HALF_RANGE) begin
      step = step_raw - mfau_pkg::FULL_RANGE;
    end else begin
      step = step_raw;
    end
    new_sum = old_sum + {{(32-SW){step[SW-1]}}, step};
  end

  // Table write-back.
  always_ff @(posedge clk) begin
    if (upd) begin
      last_angle[head.idx] <= head.angle;
      angle_sum[head.idx]  <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (upd) begin
      seen[head.idx] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {5'd0,
                  head.id_ok ? new_sum : 32'd0,
                  head.id_ok ? prev : 16'd0,
                  head.temperature,
                  head.current,
                  head.speed,
                  head.angle,
                  head.slot};
      m_tuser <= {head.backup, head.bus, head.id_ok};
    end
  end

endmodule

### src/motor_feedback_angle_unwrap.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_unwrap
// Multi-turn angle tracking from motor feedback frames on two buses.
// ----------------------------------------------------------------------------
// Each input item is one feedback frame and yields exactly one output item.
// The block accepts one item per clock cycle while the queue has room. An
// item's result passes through a queue entry and then the output register.
// The limit is the single table read-modify-write in the back end, which
// handles one frame per cycle while the output register is free or being
// emptied, so successive frames for the same slot see each other's update.
// A two-entry queue lets input and output stall independently. After reset
// every slot is unseen: its first frame adds zero to a sum of zero.
module motor_feedback_angle_unwrap (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [71:0]   s_tdata,   // std_id, byte0, byte1, ..., byte6, zero pad
  input  logic          s_tuser,   // bus
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // motor_index, angle, speed, current,
                                   // temperature, previous_angle, turn_sum, zero pad
  output logic [2:0]    m_tuser    // id_ok, bus_out, backup_update
);

  logic               push;
  logic               pop;
  mfau_pkg::frame_t   push_frame;
  mfau_pkg::frame_t   head;
  mfau_pkg::q_stat_t  q_stat;

  mfau_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  mfau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mfau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A rejected identifier leaves no slot, sum or backup flag in the item.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[106:75] == 32'd0) && !m_tuser[2]
                                && (m_tdata[2:0] == 3'd0))
    else $error("rejected item carries slot state");

  // The backup flag only appears on accepted bus 1 items.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1] && m_tuser[0])
    else $error("backup flag on wrong bus or rejected item");

  // The back end never takes an item from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // No output item right after reset.
  assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

### verif/motor_feedback_angle_unwrap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_angle_unwrap_tb
// Self-checking bench for the multi-turn angle tracker. A directed list of
// frames covers the field extremes, identifiers just inside and outside the
// motor range, the backup slot and unwrap steps on both sides of the half
// range. Random frames follow. Each accepted frame is run through an
// in-bench copy of the slot table, and every output item is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module motor_feedback_angle_unwrap_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_FRAMES  = 1000;

  // One feedback frame as presented on the input stream.
  typedef struct packed {
    logic        bus;
    logic [10:0] std_id;
    logic [7:0]  ang_hi;
    logic [7:0]  ang_lo;
    logic [7:0]  spd_hi;
    logic [7:0]  spd_lo;
    logic [7:0]  cur_hi;
    logic [7:0]  cur_lo;
    logic [7:0]  temp;
  } frame_in_t;

  // One decoded result item.
  typedef struct packed {
    logic        id_ok;
    logic        bus_out;
    logic [2:0]  motor_index;
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  temperature;
    logic [15:0] previous_angle;
    logic [31:0] turn_sum;
    logic        backup_update;
  } feedback_t;

  // A directed frame, with its result typed in where it is obvious.
  typedef struct packed {
    frame_in_t frm;
    logic      typed;
    feedback_t want;
  } plan_row_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata  = '0;   // std_id, byte0, byte1, ..., byte6, zero pad
  logic         s_tuser  = 1'b0; // bus
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;         // motor_index, angle, speed, current,
                                 // temperature, previous_angle, turn_sum, zero pad
  logic [2:0]   m_tuser;         // id_ok, bus_out, backup_update

  // Predicted slot table.
  logic [15:0] prev_angle_tab [mfau_pkg::TABLE_SIZE];
  logic        slot_seen      [mfau_pkg::TABLE_SIZE];
  logic [31:0] turn_acc       [mfau_pkg::TABLE_SIZE];

  feedback_t pending_feedback [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  bit        idle_on    = 1'b1;
  int        quiet_cycles = 0;
  int        ready_hold   = 0;

  motor_feedback_angle_unwrap i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Decode a frame and advance the predicted slot table by one update.
  function automatic feedback_t unwrap_feedback(input frame_in_t f);
    feedback_t r;
    logic [15:0] ang;
    logic [15:0] prev;
    logic [2:0]  slot;
    int          row;
    int          step;
    int          half;
    r    = '0;
    half = mfau_pkg::ENCODER_COUNTS / 2;
    ang  = {f.ang_hi, f.ang_lo};
    r.bus_out     = f.bus;
    r.angle       = ang;
    r.speed       = {f.spd_hi, f.spd_lo};
    r.current     = {f.cur_hi, f.cur_lo};
    r.temperature = f.temp;
    if (f.std_id >= mfau_pkg::BASE_ID &&
        f.std_id < mfau_pkg::BASE_ID + mfau_pkg::SLOTS_PER_BUS) begin
      slot = 3'(f.std_id - mfau_pkg::BASE_ID);
      row  = int'(f.bus) * mfau_pkg::SLOTS_PER_BUS + int'(slot);
      // The first frame of a slot is its own reference, so it adds zero.
      prev = slot_seen[row] ? prev_angle_tab[row] : ang;
      slot_seen[row]      = 1'b1;
      prev_angle_tab[row] = ang;
      // Unwrap once; raw values above the encoder range pass as they are.
      step = int'(ang) - int'(prev);
      if (step < -half) begin
        step = step + mfau_pkg::ENCODER_COUNTS;
      end else if (step > half) begin
        step = step - mfau_pkg::ENCODER_COUNTS;
      end
      turn_acc[row] = turn_acc[row] + 32'(step);
      r.id_ok          = 1'b1;
      r.motor_index    = slot;
      r.previous_angle = prev;
      r.turn_sum       = turn_acc[row];
      r.backup_update  = f.bus && (f.std_id == mfau_pkg::BACKUP_ID);
    end
    return r;
  endfunction

  function automatic frame_in_t make_frame(input logic bus, input logic [10:0] id,
                                           input logic [15:0] ang, input logic [15:0] spd,
                                           input logic [15:0] cur, input logic [7:0] temp);
    frame_in_t f;
    f.bus    = bus;
    f.std_id = id;
    {f.ang_hi, f.ang_lo} = ang;
    {f.spd_hi, f.spd_lo} = spd;
    {f.cur_hi, f.cur_lo} = cur;
    f.temp   = temp;
    return f;
  endfunction

  function automatic feedback_t make_result(input logic ok, input logic bus,
                                            input logic [2:0] idx, input logic [15:0] ang,
                                            input logic [15:0] spd, input logic [15:0] cur,
                                            input logic [7:0] temp, input logic [15:0] prev,
                                            input logic [31:0] sum, input logic backup);
    feedback_t r;
    r.id_ok          = ok;
    r.bus_out        = bus;
    r.motor_index    = idx;
    r.angle          = ang;
    r.speed          = spd;
    r.current        = cur;
    r.temperature    = temp;
    r.previous_angle = prev;
    r.turn_sum       = sum;
    r.backup_update  = backup;
    return r;
  endfunction

  // Queue a frame for the directed list; untyped rows use the predictor.
  task automatic add_row(input frame_in_t f, input logic typed, input feedback_t want);
    plan_row_t p;
    p.frm   = f;
    p.typed = typed;
    p.want  = want;
    plan.push_back(p);
  endtask

  // Present one frame, hold it until accepted, then record its prediction.
  task automatic drive_frame(input frame_in_t f, input logic typed, input feedback_t want);
    int gap;
    feedback_t got;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= f.bus;
    s_tdata  <= {5'b0, f.temp, f.cur_lo, f.cur_hi, f.spd_lo, f.spd_hi,
                 f.ang_lo, f.ang_hi, f.std_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = unwrap_feedback(f);
    pending_feedback.push_back(typed ? want : got);
  endtask

  task automatic send(input frame_in_t f);
    drive_frame(f, 1'b0, '0);
  endtask

  // Random frame: mostly valid motor identifiers, with angles near the slot's last
  // angle, about half a range from it, or random; the rest random identifiers.
  function automatic frame_in_t random_frame();
    frame_in_t f;
    logic [15:0] base;
    logic [15:0] ang;
    logic [2:0]  slot;
    logic        bus;
    int          row;
    int          r;
    bus  = 1'($urandom);
    slot = 3'($urandom);
    row  = int'(bus) * mfau_pkg::SLOTS_PER_BUS + int'(slot);
    base = slot_seen[row] ? prev_angle_tab[row]
                          : 16'($urandom_range(0, mfau_pkg::ENCODER_COUNTS - 1));
    r    = $urandom_range(0, 99);
    if (r < 25) begin
      ang = 16'($urandom);
    end else if (r < 60) begin
      ang = base + 16'($urandom_range(0, 1000)) - 16'd500;
    end else if (r < 85) begin
      // Steps right around the half range, either direction.
      if ($urandom_range(0, 1)) ang = base + 16'($urandom_range(4094, 4098));
      else                      ang = base - 16'($urandom_range(4094, 4098));
    end else begin
      ang = 16'($urandom_range(0, mfau_pkg::ENCODER_COUNTS - 1));
    end
    f = make_frame(bus, mfau_pkg::BASE_ID + 11'(slot), ang, 16'($urandom), 16'($urandom),
                   8'($urandom));
    if ($urandom_range(0, 99) < 15) f.std_id = 11'($urandom);
    return f;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output stall pattern.
  always @(negedge clk) begin : ready_gen
    int n;
    if (ready_hold > 0) begin
      m_tready   <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      n = pick_gap();
      if (n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready   <= 1'b0;
        ready_hold = n - 1;
      end
    end
  end

  // Check each accepted result item against the oldest prediction.
  always @(posedge clk) begin : result_check
    feedback_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_feedback.size() == 0) begin
        $error("result item with no frame pending: tdata %0h tuser %0h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = pending_feedback.pop_front();
        compare_field("id_ok",          32'(want.id_ok),          32'(m_tuser[0]));
        compare_field("bus_out",        32'(want.bus_out),        32'(m_tuser[1]));
        compare_field("backup_update",  32'(want.backup_update),  32'(m_tuser[2]));
        compare_field("motor_index",    32'(want.motor_index),    32'(m_tdata[2:0]));
        compare_field("angle",          32'(want.angle),          32'(m_tdata[18:3]));
        compare_field("speed",          32'(want.speed),          32'(m_tdata[34:19]));
        compare_field("current",        32'(want.current),        32'(m_tdata[50:35]));
        compare_field("temperature",    32'(want.temperature),    32'(m_tdata[58:51]));
        compare_field("previous_angle", 32'(want.previous_angle), 32'(m_tdata[74:59]));
        compare_field("turn_sum",       want.turn_sum,            m_tdata[106:75]);
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("motor_feedback_angle_unwrap_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k;
    for (k = 0; k < mfau_pkg::TABLE_SIZE; k++) begin
      prev_angle_tab[k] = '0;
      slot_seen[k]      = 1'b0;
      turn_acc[k]       = '0;
    end

    // Directed frames: extremes, first frames, out-of-range identifiers.
    add_row(make_frame(1'b0, 11'h201, 16'h0000, 16'h7FFF, 16'h8000, 8'h00), 1'b1,
            make_result(1'b1, 1'b0, 3'd0, 16'h0000, 16'h7FFF, 16'h8000, 8'h00, 16'h0000,
                        32'd0, 1'b0));
    add_row(make_frame(1'b1, 11'h208, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF), 1'b1,
            make_result(1'b1, 1'b1, 3'd7, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF, 16'hFFFF,
                        32'd0, 1'b0));
    add_row(make_frame(1'b1, mfau_pkg::BACKUP_ID, 16'h1234, 16'h0000, 16'hFFFF, 8'h55), 1'b1,
            make_result(1'b1, 1'b1, 3'd2, 16'h1234, 16'h0000, 16'hFFFF, 8'h55, 16'h1234,
                        32'd0, 1'b1));
    add_row(make_frame(1'b0, mfau_pkg::BACKUP_ID, 16'h0AAA, 16'hFFFF, 16'h0000, 8'hAA), 1'b1,
            make_result(1'b1, 1'b0, 3'd2, 16'h0AAA, 16'hFFFF, 16'h0000, 8'hAA, 16'h0AAA,
                        32'd0, 1'b0));
    add_row(make_frame(1'b0, 11'h000, 16'hFFFF, 16'h8000, 16'h8000, 8'hFF), 1'b1,
            make_result(1'b0, 1'b0, 3'd0, 16'hFFFF, 16'h8000, 16'h8000, 8'hFF, 16'h0000,
                        32'd0, 1'b0));
    add_row(make_frame(1'b1, 11'h7FF, 16'h5555, 16'hAAAA, 16'h5555, 8'h80), 1'b1,
            make_result(1'b0, 1'b1, 3'd0, 16'h5555, 16'hAAAA, 16'h5555, 8'h80, 16'h0000,
                        32'd0, 1'b0));
    add_row(make_frame(1'b1, 11'h200, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h7F), 1'b1,
            make_result(1'b0, 1'b1, 3'd0, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h7F, 16'h0000,
                        32'd0, 1'b0));
    add_row(make_frame(1'b0, 11'h209, 16'h0001, 16'h0001, 16'hFFFF, 8'h01), 1'b1,
            make_result(1'b0, 1'b0, 3'd0, 16'h0001, 16'h0001, 16'hFFFF, 8'h01, 16'h0000,
                        32'd0, 1'b0));
    // Unwrap steps on one slot: exactly half range, just past it, raw overrange.
    add_row(make_frame(1'b0, 11'h202, 16'd100,   16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd4196,  16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd100,   16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd4197,  16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd100,   16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd8191,  16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd0,     16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'hFFFF,  16'd1, 16'd2, 8'd3), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h202, 16'd0,     16'd1, 16'd2, 8'd3), 1'b0, '0);
    // Revisit slots already seen, on both buses, and the same slots on the other bus.
    add_row(make_frame(1'b1, 11'h201, 16'h2000, 16'h1111, 16'h2222, 8'h33), 1'b0, '0);
    add_row(make_frame(1'b1, 11'h201, 16'h0000, 16'h1111, 16'h2222, 8'h33), 1'b0, '0);
    add_row(make_frame(1'b0, 11'h201, 16'h1FFF, 16'h4444, 16'h5555, 8'h66), 1'b0, '0);
    add_row(make_frame(1'b1, mfau_pkg::BACKUP_ID, 16'h0234, 16'h7777, 16'h8888, 8'h99),
            1'b0, '0);
    add_row(make_frame(1'b0, 11'h208, 16'h0F0F, 16'hF0F0, 16'h0F0F, 8'hF0), 1'b0, '0);
    add_row(make_frame(1'b1, 11'h208, 16'h0001, 16'h0000, 16'h0000, 8'h00), 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) drive_frame(plan[i].frm, plan[i].typed, plan[i].want);

    // Random frames, with idle stretches switched on and off along the way.
    idle_on = 1'b1;
    for (k = 0; k < RANDOM_FRAMES; k++) begin
      if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
      if (k == RANDOM_FRAMES / 2) begin
        // Let the output side run dry before going on.
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_feedback.size() != 0) @(posedge clk);
      end
      send(random_frame());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("motor_feedback_angle_unwrap_tb OK");
    end else begin
      $display("motor_feedback_angle_unwrap_tb NOT OK");
    end
    $finish;
  end

endmodule
